// ===== sv/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list: request kinds,
// result status codes, field widths and the command that steers the cells.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int unsigned DEPTH_DEF = 32;
	localparam int unsigned POS_W     = 8;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned TYPE_W    = 2;
	localparam int unsigned STAT_W    = 2;

	// request kinds
	localparam logic [TYPE_W-1:0] REQ_READ   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic             ins;   // open a slot at index, shift later cells up
		logic             del;   // close the slot at index, shift later cells down
		logic             take;  // drive the element at index onto the read bus
		logic [POS_W-1:0] index; // zero-based slot index (position - 1)
	} cmd_t;

endpackage

// ===== sv/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One slot of the list. Holds one element and, on an insert or delete,
// takes the element of its lower or upper neighbor so the row shifts at once.
// ----------------------------------------------------------------------------
module pal_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                          clk,
	input  pal_pkg::cmd_t                 cmd,
	input  logic [pal_pkg::DATA_W-1:0]    value,
	input  logic [pal_pkg::DATA_W-1:0]    left_data,
	input  logic [pal_pkg::DATA_W-1:0]    right_data,
	output logic [pal_pkg::DATA_W-1:0]    data,
	output logic [pal_pkg::DATA_W-1:0]    rd_data
);
	import pal_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_W-1:0] data_q;
	logic              at_idx;
	logic              above_idx;

	assign at_idx    = (cmd.index == MY_IDX);
	assign above_idx = (MY_IDX > cmd.index);

	// shift or load the slot
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_idx) begin
				data_q <= value;
			end else if (above_idx) begin
				data_q <= left_data;
			end
		end else if (cmd.del) begin
			if (at_idx || above_idx) begin
				data_q <= right_data;
			end
		end
	end

	assign data    = data_q;
	assign rd_data = (cmd.take && at_idx) ? data_q : '0;

endmodule

// ===== sv/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// pal_ctrl
// Length counter and request checker. Decides the status of each request
// and issues the shift command to the row of cells.
// ----------------------------------------------------------------------------
module pal_ctrl #(
	parameter int unsigned DEPTH = pal_pkg::DEPTH_DEF,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [pal_pkg::TYPE_W-1:0]    req_type,
	input  logic [pal_pkg::POS_W-1:0]     position,
	output pal_pkg::cmd_t                 cmd,
	output logic [pal_pkg::STAT_W-1:0]    status,
	output logic [CNT_W-1:0]              count_next
);
	import pal_pkg::*;

	localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             pos_in_list;
	logic             pos_in_ins;
	logic             is_empty;
	logic             ok_ins;
	logic             ok_del;
	logic             ok_read;

	assign pos_ext  = CMP_W'(position);
	assign cnt_ext  = CMP_W'(count_q);
	assign is_empty = (count_q == '0);

	assign pos_in_list = (position != '0) && (pos_ext <= cnt_ext);
	assign pos_in_ins  = (position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));

	// check the request
	always_comb begin
		status  = ST_BADPOS;
		ok_ins  = 1'b0;
		ok_del  = 1'b0;
		ok_read = 1'b0;
		case (req_type)
			REQ_READ: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else if (pos_in_list) begin
					status  = ST_OK;
					ok_read = 1'b1;
				end
			end
			REQ_INSERT: begin
				if (!pos_in_ins) begin
					status = ST_BADPOS;
				end else if (count_q == FULL_CNT) begin
					status = ST_FULL;
				end else begin
					status = ST_OK;
					ok_ins = 1'b1;
				end
			end
			REQ_DELETE: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else if (pos_in_list) begin
					status = ST_OK;
					ok_del = 1'b1;
				end
			end
			default: begin
				status = ST_BADPOS;
			end
		endcase
	end

	// drive the row
	assign cmd.ins   = fire && ok_ins;
	assign cmd.del   = fire && ok_del;
	assign cmd.take  = ok_read || ok_del;
	assign cmd.index = position - POS_W'(1);

	always_comb begin
		count_next = count_q;
		if (ok_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ok_del) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// advance the length on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_next;
		end
	end

`ifndef SYNTH
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not shrink the list");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("length moved without a transfer");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("length above depth");
`endif

endmodule

// ===== sv/positional_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of up to DEPTH signed 32-bit elements, addressed by 1-based
// position: read, insert with shift up, delete with shift down.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with req_type, position and value.
//   Each request gives one result on out_valid/out_ready: status, element
//   and the list length after the request.
//   The result is registered; out_valid rises in the cycle after the transfer.
//   Throughput: one request per cycle while the receiver takes each result.
//   Every slot is a cell of its own that takes its neighbor's element on
//   the same edge, so an insert or delete moves the whole list at once.
//   The result sits in an output register; in_ready stays high while that
//   register is empty or being drained, so a new request is taken in the
//   same cycle the previous result is transferred.
//   When the receiver stalls, the result holds and in_ready drops until it
//   is taken.
//   Reset empties the list and clears out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
	parameter int unsigned DEPTH = pal_pkg::DEPTH_DEF,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pal_pkg::TYPE_W-1:0]     req_type,
	input  logic [pal_pkg::POS_W-1:0]      position,
	input  logic signed [pal_pkg::DATA_W-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pal_pkg::STAT_W-1:0]     status,
	output logic signed [pal_pkg::DATA_W-1:0] element,
	output logic [CNT_W-1:0]               count
);
	import pal_pkg::*;

	cmd_t              cmd;
	logic              fire;
	logic [STAT_W-1:0] status_d;
	logic [CNT_W-1:0]  count_d;
	logic [DATA_W-1:0] elem_d;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] cell_rd   [DEPTH];

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] element_q;
	logic [CNT_W-1:0]  count_q;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	pal_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req_type   (req_type),
		.position   (position),
		.cmd        (cmd),
		.status     (status_d),
		.count_next (count_d)
	);

	// row of cells, each linked to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pal_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (value),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// collect the selected element from the read bus
	always_comb begin
		elem_d = '0;
		for (int unsigned k = 0; k < DEPTH; k++) begin
			elem_d = elem_d | cell_rd[k];
		end
	end

	// hold the result until it is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_d;
			element_q <= elem_d;
			count_q   <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign count     = count_q;

`ifndef SYNTH
	a_stall_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request taken while result stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CNT_W'(DEPTH))
		else $error("reported length above depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> element == '0)
		else $error("element nonzero on error");
`endif

endmodule
